FILE: rtl/core/assert_macros.svh
// assertion macros shared by the checker files
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rgbad check failed");

// next-cycle implication, off during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rgbad check failed");

`endif

FILE: rtl/core/rgbad_pkg.sv
// shared constants and types of the rgba 2x2 downsampler
// no dependencies
package rgbad_pkg;

  localparam int CFG_W        = 11;
  localparam int PIX_W        = 8;
  localparam int CHANNELS     = 4;
  localparam int DATA_W       = PIX_W * CHANNELS;
  localparam int SUM_W        = PIX_W + 1;
  localparam int TOT_W        = PIX_W + 2;
  localparam int LINE_W       = SUM_W * CHANNELS;
  localparam int MAX_WIDTH_DEF = 1024;
  localparam int HEIGHT_LIMIT = 1024;
  localparam int ROW_W        = 10;
  localparam int IDX_W        = 1;

  localparam logic [CFG_W-1:0] RESET_WIDTH  = 11'd512;
  localparam logic [CFG_W-1:0] RESET_HEIGHT = 11'd1024;
  localparam logic [TOT_W-1:0] ALPHA_CUT    = 10'd127;
  localparam logic [PIX_W-1:0] ALPHA_FULL   = 8'd255;
  localparam logic [PIX_W-1:0] ALPHA_NONE   = 8'd0;

  typedef enum logic [IDX_W-1:0] {
    REG_SOURCE_WIDTH  = 1'b0,
    REG_SOURCE_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic       valid;
    logic       emit;
    logic       fv;
    logic [1:0] sh;
    logic       done;
  } stage_ctrl_t;

endpackage

FILE: rtl/core/rgbad_ram.sv
// generic single-port ram with registered read
// no dependencies
module rgbad_ram #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 512,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic             re,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

FILE: rtl/core/rgba_box_downsample_alpha_threshold.sv
// top level of the rgba 2x2 box downsampler with binary alpha
// depends on rgbad_pkg and rgbad_ram
//
// source pixels enter on the s_ channel in raster order, one request per pixel,
// tdata holds red, green, blue, alpha from the lowest byte up
// pixels of the half-size level leave on the m_ channel, tlast marks the last
// pixel of the level
// cfg_we with cfg_index and cfg_data sets source width or height and restarts
// the level at row 0, column 0
// a result passes the stage register and then the output register after the request
// of the pixel that closes its block, and one pixel is taken every cycle while s_tready is high
// the line memory keeps pair sums of even rows, one port that is written on
// even rows and read on odd rows, at most one access per request
// reset sets the size to 512 by 1024 and the position to the level start, no
// clearing pass is needed
// when m_tready is low the output register and the one stage in flight hold,
// s_tready drops only once both are full
module rgba_box_downsample_alpha_threshold #(
  parameter int MAX_WIDTH = rgbad_pkg::MAX_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [rgbad_pkg::DATA_W-1:0]  s_tdata,   // red, green, blue, alpha
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [rgbad_pkg::DATA_W-1:0]  m_tdata,   // out_red, out_green, out_blue, out_alpha
  output logic                          m_tlast,   // level_done
  input  logic                          cfg_we,
  input  logic [rgbad_pkg::IDX_W-1:0]   cfg_index,
  input  logic [rgbad_pkg::CFG_W-1:0]   cfg_data
);
  import rgbad_pkg::*;

  localparam int LINE_DEPTH = MAX_WIDTH / 2;
  localparam int AW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int CW = $clog2(MAX_WIDTH) + 1;
  localparam int EW = ((CW > CFG_W) ? CW : CFG_W) + 1;

  logic [CFG_W-1:0] cfg_width;
  logic [CFG_W-1:0] cfg_height;
  logic [CW-1:0]    col;
  logic [ROW_W-1:0] row;
  logic [PIX_W-1:0] hsum [CHANNELS];

  logic [EW-1:0]    w_eff;
  logic [CFG_W-1:0] h_eff;
  logic             outside;
  logic [CW-1:0]    cur_col;
  logic [ROW_W-1:0] cur_row;
  logic             fh;
  logic             fv;
  logic [EW-1:0]    last_col;
  logic [CFG_W-1:0] last_row;
  logic             done;
  logic [CW-2:0]    idx_full;
  logic [AW-1:0]    idx;
  logic             store_h;
  logic             pair_phase;
  logic             line_wr;
  logic             emit;
  logic [SUM_W-1:0] pair [CHANNELS];
  logic [LINE_W-1:0] line_wdata;
  logic [LINE_W-1:0] line_rdata;
  logic [EW-1:0]    col_inc;
  logic [CFG_W-1:0] row_inc;
  logic [CW-1:0]    col_next;
  logic [ROW_W-1:0] row_next;
  logic             accept;

  stage_ctrl_t      s1;
  logic [SUM_W-1:0] s1_pair [CHANNELS];
  logic             s1_adv;
  logic             out_load;
  logic [TOT_W-1:0] tot [CHANNELS];
  logic [TOT_W-1:0] avg [CHANNELS];
  logic [DATA_W-1:0] result;

  // effective sizes and position
  always_comb begin
    if (cfg_width == '0) begin
      w_eff = EW'(1);
    end else if (EW'(cfg_width) > EW'(MAX_WIDTH)) begin
      w_eff = EW'(MAX_WIDTH);
    end else begin
      w_eff = EW'(cfg_width);
    end
    if (cfg_height == '0) begin
      h_eff = CFG_W'(1);
    end else if (cfg_height > CFG_W'(HEIGHT_LIMIT)) begin
      h_eff = CFG_W'(HEIGHT_LIMIT);
    end else begin
      h_eff = cfg_height;
    end
  end

  assign outside  = (EW'(col) >= w_eff) || (CFG_W'(row) >= h_eff);
  assign cur_col  = outside ? '0 : col;
  assign cur_row  = outside ? '0 : row;
  assign fh       = w_eff >= EW'(2);
  assign fv       = h_eff >= CFG_W'(2);
  assign last_col = fh ? ((w_eff & ~EW'(1)) - EW'(1)) : '0;
  assign last_row = fv ? ((h_eff & ~CFG_W'(1)) - CFG_W'(1)) : '0;
  assign done     = (EW'(cur_col) == last_col) && (CFG_W'(cur_row) == last_row);
  assign idx_full = cur_col[CW-1:1];
  assign idx      = (fh && (EW'(idx_full) < EW'(LINE_DEPTH))) ? AW'(idx_full) : '0;

  assign store_h    = fh && !cur_col[0];
  assign pair_phase = (fh || fv) && !store_h;
  assign line_wr    = pair_phase && fv && !cur_row[0];
  assign emit       = pair_phase && !(fv && !cur_row[0]);

  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      pair[c] = fh ? ({1'b0, hsum[c]} + {1'b0, s_tdata[c*PIX_W +: PIX_W]})
                   : {1'b0, s_tdata[c*PIX_W +: PIX_W]};
      line_wdata[c*SUM_W +: SUM_W] = pair[c];
    end
  end

  assign col_inc = EW'(cur_col) + EW'(1);
  assign row_inc = CFG_W'(cur_row) + CFG_W'(1);

  always_comb begin
    if (col_inc >= w_eff) begin
      col_next = '0;
      row_next = (row_inc >= h_eff) ? '0 : row_inc[ROW_W-1:0];
    end else begin
      col_next = col_inc[CW-1:0];
      row_next = cur_row;
    end
  end

  // handshake
  assign out_load = s1.valid && s1.emit && (!m_tvalid || m_tready);
  assign s1_adv   = !s1.valid || !s1.emit || !m_tvalid || m_tready;
  assign s_tready = s1_adv;
  assign accept   = s_tvalid && s_tready;

  rgbad_ram #(
    .WIDTH (LINE_W),
    .DEPTH (LINE_DEPTH)
  ) u_line (
    .clk   (clk),
    .we    (accept && line_wr),
    .re    (accept && emit && fv),
    .addr  (idx),
    .wdata (line_wdata),
    .rdata (line_rdata)
  );

  // config and position
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_width  <= RESET_WIDTH;
      cfg_height <= RESET_HEIGHT;
      col        <= '0;
      row        <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_SOURCE_WIDTH:  cfg_width  <= cfg_data;
        REG_SOURCE_HEIGHT: cfg_height <= cfg_data;
        default: ;
      endcase
      col <= '0;
      row <= '0;
    end else if (accept) begin
      col <= col_next;
      row <= row_next;
    end
  end

  // pending even column
  always_ff @(posedge clk) begin
    if (accept && store_h) begin
      for (int c = 0; c < CHANNELS; c++) begin
        hsum[c] <= s_tdata[c*PIX_W +: PIX_W];
      end
    end
  end

  // stage in flight
  always_ff @(posedge clk) begin
    if (rst) begin
      s1 <= '0;
    end else if (s1_adv) begin
      s1.valid <= accept;
      s1.emit  <= accept && emit;
      s1.fv    <= fv;
      s1.sh    <= {1'b0, fh} + {1'b0, fv};
      s1.done  <= done;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int c = 0; c < CHANNELS; c++) begin
        s1_pair[c] <= pair[c];
      end
    end
  end

  // block mean and alpha cut
  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      tot[c] = s1.fv ? ({1'b0, line_rdata[c*SUM_W +: SUM_W]} + {1'b0, s1_pair[c]})
                     : {1'b0, s1_pair[c]};
      avg[c] = tot[c] >> s1.sh;
    end
    for (int c = 0; c < CHANNELS - 1; c++) begin
      result[c*PIX_W +: PIX_W] = avg[c][PIX_W-1:0];
    end
    result[(CHANNELS-1)*PIX_W +: PIX_W] =
      (avg[CHANNELS-1] >= ALPHA_CUT) ? ALPHA_FULL : ALPHA_NONE;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= result;
      m_tlast <= s1.done;
    end
  end

endmodule

FILE: rtl/core/rgbad_checker.sv
// port checks for the rgba 2x2 downsampler, bound to the top level
// depends on rgbad_pkg and assert_macros.svh
`include "assert_macros.svh"

module rgbad_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [rgbad_pkg::DATA_W-1:0]  m_tdata,
  input logic                          m_tlast
);
  import rgbad_pkg::*;

  // stalled result stays offered
  `ASSERT_NEXT(a_hold_valid, clk, rst, m_tvalid && !m_tready, m_tvalid)
  `ASSERT_NEXT(a_hold_data, clk, rst, m_tvalid && !m_tready,
    $stable(m_tdata) && $stable(m_tlast))
  // alpha leaves as fully clear or fully opaque
  `ASSERT_SAME(a_alpha_binary, clk, rst, m_tvalid,
    m_tdata[DATA_W-1 -: PIX_W] == ALPHA_NONE || m_tdata[DATA_W-1 -: PIX_W] == ALPHA_FULL)
  // a ready sink never stalls the source
  `ASSERT_SAME(a_no_stall, clk, rst, m_tready, s_tready)

endmodule

bind rgba_box_downsample_alpha_threshold rgbad_checker u_rgbad_checker (.*);

FILE: dv/tb_top.sv
// testbench for the rgba 2x2 box downsampler with binary alpha
// streams source levels of many sizes under random idling, predicts each mip pixel
// locally and checks it field by field; depends on rgbad_pkg and the rtl top level
`timescale 1ns / 100ps

module tb_top;
  import rgbad_pkg::*;

  localparam int DIM_LIMIT  = 1024;
  localparam int LINE_DEPTH = DIM_LIMIT / 2;
  localparam int DRAIN_WAIT = 6;
  localparam int RANDOM_ITEMS = 300;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       level_done;
  } mip_pixel_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [DATA_W-1:0] s_tdata = '0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [DATA_W-1:0] m_tdata;
  logic              m_tlast;
  logic              cfg_we = 1'b0;
  cfg_reg_t          cfg_index = REG_SOURCE_WIDTH;
  logic [CFG_W-1:0]  cfg_data = '0;

  // predictor state
  logic [CFG_W-1:0] width_reg = RESET_WIDTH;
  logic [CFG_W-1:0] height_reg = RESET_HEIGHT;
  logic [8:0]       line_sums [LINE_DEPTH][4];
  logic [7:0]       held_px [4];
  int unsigned      col_pos = 0;
  int unsigned      row_pos = 0;

  logic [31:0] src_pixels [$];
  mip_pixel_t  mip_expected [$];
  mip_pixel_t  mip_seen;
  int          error_count = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  bit          burst_req = 1'b0;
  int          burst_left = 0;

  rgba_box_downsample_alpha_threshold uut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tlast(m_tlast),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  function automatic int unsigned eff_dim(input logic [CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > DIM_LIMIT) return DIM_LIMIT;
    return v;
  endfunction

  task automatic downsample_pixel(input logic [31:0] d);
    int unsigned w, h, col, row, last_col, last_row, idx, sh, t;
    int unsigned pair [4];
    int unsigned tot [4];
    logic [7:0]  px [4];
    bit          fh, fv, done;
    mip_pixel_t  r;
    int          c;
    w = eff_dim(width_reg);
    h = eff_dim(height_reg);
    col = col_pos;
    row = row_pos;
    if (col >= w || row >= h) begin
      col = 0;
      row = 0;
    end
    fh = w >= 2;
    fv = h >= 2;
    for (c = 0; c < 4; c++) px[c] = d[8*c +: 8];
    last_col = fh ? (w & ~32'd1) - 1 : 0;
    last_row = fv ? (h & ~32'd1) - 1 : 0;
    done = (col == last_col) && (row == last_row);
    idx = fh ? col >> 1 : 0;
    if (idx >= LINE_DEPTH) idx = 0;
    if (fh || fv) begin
      if (fh && col % 2 == 0) begin
        for (c = 0; c < 4; c++) held_px[c] = px[c];
      end else begin
        for (c = 0; c < 4; c++) pair[c] = fh ? held_px[c] + px[c] : px[c];
        if (fv && row % 2 == 0) begin
          for (c = 0; c < 4; c++) line_sums[idx][c] = 9'(pair[c]);
        end else begin
          sh = (fh ? 1 : 0) + (fv ? 1 : 0);
          for (c = 0; c < 4; c++) begin
            t = fv ? line_sums[idx][c] + pair[c] : pair[c];
            tot[c] = t >> sh;
          end
          r.red = 8'(tot[0]);
          r.green = 8'(tot[1]);
          r.blue = 8'(tot[2]);
          r.alpha = (tot[3] >= ALPHA_CUT) ? ALPHA_FULL : ALPHA_NONE;
          r.level_done = done;
          mip_expected.push_back(r);
        end
      end
    end
    col++;
    if (col >= w) begin
      col = 0;
      row++;
      if (row >= h) row = 0;
    end
    col_pos = col;
    row_pos = row;
  endtask

  // source side
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      width_reg = RESET_WIDTH;
      height_reg = RESET_HEIGHT;
      col_pos = 0;
      row_pos = 0;
      for (int c = 0; c < 4; c++) held_px[c] = '0;
    end else begin
      if (s_tvalid && s_tready) downsample_pixel(s_tdata);
      if (!s_tvalid || s_tready) begin
        if (src_pixels.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          s_tdata <= src_pixels.pop_front();
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (rst) begin
      burst_left <= 0;
    end else if (burst_req) begin
      burst_left <= 400;
      burst_req = 1'b0;
    end else if (burst_left > 0) begin
      burst_left <= burst_left - 1;
    end
  end

  // result side
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (mip_expected.size() == 0) begin
          $error("result with no request pending: tdata %h tlast %b", m_tdata, m_tlast);
          error_count++;
        end else begin
          mip_seen = mip_expected.pop_front();
          if (m_tdata[7:0] !== mip_seen.red) begin
            $error("out_red expected %0d got %0d", mip_seen.red, m_tdata[7:0]);
            error_count++;
          end
          if (m_tdata[15:8] !== mip_seen.green) begin
            $error("out_green expected %0d got %0d", mip_seen.green, m_tdata[15:8]);
            error_count++;
          end
          if (m_tdata[23:16] !== mip_seen.blue) begin
            $error("out_blue expected %0d got %0d", mip_seen.blue, m_tdata[23:16]);
            error_count++;
          end
          if (m_tdata[31:24] !== mip_seen.alpha) begin
            $error("out_alpha expected %0d got %0d", mip_seen.alpha, m_tdata[31:24]);
            error_count++;
          end
          if (m_tlast !== mip_seen.level_done) begin
            $error("level_done expected %0b got %0b", mip_seen.level_done, m_tlast);
            error_count++;
          end
        end
      end
      if (burst_left > 0) begin
        m_tready <= 1'b0;
      end else begin
        m_tready <= $urandom_range(99) >= recv_stall_pct;
      end
    end
  end

  task automatic wait_drained();
    while (src_pixels.size() != 0 || s_tvalid || mip_expected.size() != 0 || burst_left > 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t sel, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= sel;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (sel == REG_SOURCE_WIDTH) width_reg = val;
    else height_reg = val;
    col_pos = 0;
    row_pos = 0;
  endtask

  task automatic set_size(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
    wait_drained();
    write_reg(REG_SOURCE_WIDTH, w);
    write_reg(REG_SOURCE_HEIGHT, h);
  endtask

  task automatic set_idling(input int mode);
    case (mode)
      1: begin send_idle_pct = 52; recv_stall_pct = 0; end
      2: begin send_idle_pct = 0; recv_stall_pct = 52; end
      3: begin send_idle_pct = 18; recv_stall_pct = 18; end
      default: begin send_idle_pct = 0; recv_stall_pct = 0; end
    endcase
  endtask

  function automatic logic [31:0] rand_pixel();
    logic [31:0] p;
    p = $urandom;
    case ($urandom_range(7))
      0: p = 32'h0000_0000;
      1: p = 32'hFFFF_FFFF;
      2, 3: p[31:24] = 8'($urandom_range(134, 120));
      default: ;
    endcase
    return p;
  endfunction

  function automatic logic [CFG_W-1:0] pick_dim();
    case ($urandom_range(9))
      0: return CFG_W'($urandom_range(7));
      1: return CFG_W'($urandom_range(33));
      default: return CFG_W'(1 << $urandom_range(4));
    endcase
  endfunction

  task automatic push_random(input int n);
    for (int i = 0; i < n; i++) src_pixels.push_back(rand_pixel());
  endtask

  initial begin
    int          random_pushed;
    int          phase;
    int          n;
    int unsigned level;
    logic [CFG_W-1:0] w, h;
    random_pushed = 0;
    phase = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // 2x2 blocks: zero, full, alpha just at and just below the threshold
    set_idling(0);
    set_size(11'd2, 11'd2);
    repeat (4) src_pixels.push_back(32'h0000_0000);
    repeat (4) src_pixels.push_back(32'hFFFF_FFFF);
    src_pixels.push_back(32'h7F01_80FE);
    src_pixels.push_back(32'h7F02_7F01);
    src_pixels.push_back(32'h7F03_0000);
    src_pixels.push_back(32'h7F04_FFFF);
    repeat (3) src_pixels.push_back(32'h7F55_AA11);
    src_pixels.push_back(32'h7E55_AA12);
    // one wide, one high, one by one
    set_size(11'd1, 11'd2);
    src_pixels.push_back(32'h7FFF_00FF);
    src_pixels.push_back(32'h7F00_FF00);
    set_size(11'd2, 11'd1);
    src_pixels.push_back(32'h80FF_FFFF);
    src_pixels.push_back(32'h7DFF_FFFE);
    set_size(11'd1, 11'd1);
    src_pixels.push_back(32'hFFFF_FFFF);
    src_pixels.push_back(32'h1234_5678);

    // full width level with oversize width, receiver held off to fill the pipe
    set_size(11'd2047, 11'd1);
    set_idling(0);
    push_random(DIM_LIMIT);
    burst_req = 1'b1;
    set_size(11'd0, 11'd2047);
    set_idling(3);
    push_random(200);
    set_size(11'd1024, 11'd0);
    set_idling(1);
    push_random(256);
    set_size(11'd1, 11'd1024);
    set_idling(2);
    push_random(100);

    while (random_pushed < RANDOM_ITEMS) begin
      wait_drained();
      set_idling(phase % 4);
      w = pick_dim();
      h = pick_dim();
      case ($urandom_range(3))
        0: write_reg(REG_SOURCE_WIDTH, w);
        1: write_reg(REG_SOURCE_HEIGHT, h);
        default: begin
          write_reg(REG_SOURCE_WIDTH, w);
          write_reg(REG_SOURCE_HEIGHT, h);
        end
      endcase
      level = eff_dim(width_reg) * eff_dim(height_reg);
      if (level <= 1) n = $urandom_range(8, 3);
      else if (level <= 300) n = level * $urandom_range(2, 1);
      else n = $urandom_range(300, 64);
      if (n > RANDOM_ITEMS - random_pushed) n = RANDOM_ITEMS - random_pushed;
      push_random(n);
      random_pushed += n;
      phase++;
    end

    wait_drained();
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/rgbad_pkg.sv
rtl/core/rgbad_ram.sv
rtl/core/rgba_box_downsample_alpha_threshold.sv
rtl/core/rgbad_checker.sv
dv/tb_top.sv
